/* rtl/closest_point_on_triangle_unit_defines.svh */
`ifndef CLOSEST_POINT_ON_TRIANGLE_UNIT_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define CPT_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* rtl/cptri_pkg.sv */
`timescale 1ns / 1ps

package cptri_pkg;

  localparam int CoordBits = 16;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [2:0] {
    RegA     = 3'd0,
    RegB     = 3'd1,
    RegC     = 3'd2,
    RegAb    = 3'd3,
    RegBc    = 3'd4,
    RegAc    = 3'd5,
    RegIn    = 3'd6,
    RegDegen = 3'd7
  } region_e;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_a_z;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_b_z;
    coord_t vert_c_x;
    coord_t vert_c_y;
    coord_t vert_c_z;
  } query_t;

  typedef struct packed {
    coord_t  near_x;
    coord_t  near_y;
    coord_t  near_z;
    region_e region;
  } result_t;

  // side data that rides along the pipeline
  typedef struct packed {
    region_e      region;
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
  } side_t;

endpackage

/* rtl/closest_point_on_triangle_unit.sv */
// Closest point on a triangle: fully pipelined, one query word per cycle.
// The pipeline depth is set by the restoring divider, one quotient bit per
// stage.
// Throughput one word per clock; busy stays low and the receiver cannot stall.
// Reset (rst_ni low, async) clears all valid bits; data registers keep junk.
`timescale 1ns / 1ps
`include "closest_point_on_triangle_unit_defines.svh"

module closest_point_on_triangle_unit #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  cptri_pkg::query_t  query_i,
  output logic               res_stb_o,
  output cptri_pkg::result_t result_o
);

  import cptri_pkg::*;

  localparam int C       = CoordBits;
  localparam int F       = WEIGHT_FRAC_BITS;
  localparam int DW      = C + 1;          // coordinate difference
  localparam int PDW     = 2 * DW;         // difference product
  localparam int DDW     = 2 * C + 4;      // dot product
  localparam int TW      = 4 * C + 9;      // triple product
  localparam int AW      = 4 * C + 11;     // area
  localparam int NW      = TW + F;         // divider numerator / quotient
  localparam int QW      = NW + 1;         // signed weight
  localparam int PW      = DW + QW;
  localparam int SW      = PW + 2;
  localparam int RW      = SW - F;
  localparam int VW      = RW + 1;
  localparam int KT      = (DDW + 31) / 32;
  localparam int KQ      = (QW + 31) / 32;
  localparam int TGW     = $bits(side_t);
  localparam int Latency = NW + 14;

  localparam logic signed [VW-1:0] SatHi = VW'(2 ** (C - 1) - 1);
  localparam logic signed [VW-1:0] SatLo = VW'(-(2 ** (C - 1)));

  assign busy = 1'b0;

  // ---------------- stage 1: input word
  logic   v1_q;
  query_t in_q;
  coord_t pt [3];
  coord_t va [3];
  coord_t vb [3];
  coord_t vc [3];
  side_t  side1;

  always_comb begin
    pt[0] = in_q.point_x;  pt[1] = in_q.point_y;  pt[2] = in_q.point_z;
    va[0] = in_q.vert_a_x; va[1] = in_q.vert_a_y; va[2] = in_q.vert_a_z;
    vb[0] = in_q.vert_b_x; vb[1] = in_q.vert_b_y; vb[2] = in_q.vert_b_z;
    vc[0] = in_q.vert_c_x; vc[1] = in_q.vert_c_y; vc[2] = in_q.vert_c_z;
    side1.region = RegA;
    for (int i = 0; i < 3; i++) begin
      side1.a[i] = va[i];
      side1.b[i] = vb[i];
      side1.c[i] = vc[i];
    end
  end

  // ---------------- stage 2: differences
  logic                 v2_q;
  side_t                side2_q;
  logic signed [DW-1:0] ab_q [3];
  logic signed [DW-1:0] ac_q [3];
  logic signed [DW-1:0] bc_q [3];
  logic signed [DW-1:0] ap_q [3];
  logic signed [DW-1:0] bp_q [3];
  logic signed [DW-1:0] cp_q [3];

  // ---------------- stage 3: products for the eight dots
  logic                  v3_q;
  side_t                 side3_q;
  logic signed [DW-1:0]  mx [8][3];
  logic signed [DW-1:0]  my [8][3];
  logic signed [PDW-1:0] prod3_q [8][3];

  // dots: snom, sdenom, tnom, tdenom, unom, udenom, AC.BP, AB.CP
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx[0][i] = ab_q[i]; my[0][i] = ap_q[i];
      mx[1][i] = ab_q[i]; my[1][i] = bp_q[i];
      mx[2][i] = ac_q[i]; my[2][i] = ap_q[i];
      mx[3][i] = ac_q[i]; my[3][i] = cp_q[i];
      mx[4][i] = bc_q[i]; my[4][i] = bp_q[i];
      mx[5][i] = bc_q[i]; my[5][i] = cp_q[i];
      mx[6][i] = ac_q[i]; my[6][i] = bp_q[i];
      mx[7][i] = ab_q[i]; my[7][i] = cp_q[i];
    end
  end

  // ---------------- stage 4: dot sums
  logic                  v4_q;
  side_t                 side4_q;
  logic signed [DDW-1:0] dot4_q [8];
  logic signed [DDW-1:0] dsum   [8];

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      dsum[j] = DDW'(prod3_q[j][0]) + DDW'(prod3_q[j][1]) + DDW'(prod3_q[j][2]);
    end
  end

  // ---------------- stages 5-6: triple products via Lagrange identity
  // sab = snom*d1 + sden*tnom, sbc = sden*tden - d2*d1, sac = d2*tnom + snom*tden
  logic                    v5_q, v6_q;
  side_t                   side5_q, side6_q;
  logic signed [DDW-1:0]   dot5_q [6];
  logic signed [DDW-1:0]   dot6_q [6];
  logic signed [DDW-1:0]   tx [6];
  logic signed [DDW-1:0]   ty [6];
  logic signed [2*DDW-1:0] tp [6];

  always_comb begin
    tx[0] = dot4_q[0]; ty[0] = dot4_q[6];
    tx[1] = dot4_q[1]; ty[1] = dot4_q[2];
    tx[2] = dot4_q[1]; ty[2] = dot4_q[3];
    tx[3] = dot4_q[7]; ty[3] = dot4_q[6];
    tx[4] = dot4_q[7]; ty[4] = dot4_q[2];
    tx[5] = dot4_q[0]; ty[5] = dot4_q[3];
  end

  for (genvar m = 0; m < 6; m++) begin : g_tmul
    cptri_mul #(.XW(DDW), .YW(DDW), .K(KT)) u_mul (
      .clk_i (clk_i),
      .x_i   (tx[m]),
      .y_i   (ty[m]),
      .p_o   (tp[m])
    );
  end

  // ---------------- stage 7: triple scalar products
  logic                  v7_q;
  side_t                 side7_q;
  logic signed [DDW-1:0] dot7_q [6];
  logic signed [TW-1:0]  sab_q, sbc_q, sac_q;

  // ---------------- stage 8: region decision, divider operands
  logic                  v8_q;
  side_t                 side8_q;
  logic signed [TW-1:0]  num1_q, num2_q;
  logic signed [AW-1:0]  den1_q, den2_q;

  region_e               rg;
  logic                  is_edg;
  logic signed [DDW-1:0] nom_sel, den_sel;
  logic signed [AW-1:0]  esum, area;
  logic signed [TW-1:0]  num1_d, num2_d;
  logic signed [AW-1:0]  den1_d, den2_d;
  side_t                 side8_d;

  always_comb begin
    rg      = RegIn;
    is_edg  = 1'b0;
    nom_sel = dot7_q[0];
    den_sel = dot7_q[1];
    if (dot7_q[2][DDW-1] && dot7_q[0][DDW-1]) begin
      rg = RegA;
    end else if (dot7_q[4][DDW-1] && dot7_q[1][DDW-1]) begin
      rg = RegB;
    end else if (dot7_q[5][DDW-1] && dot7_q[3][DDW-1]) begin
      rg = RegC;
    end else if ((sab_q[TW-1] || sab_q == '0) && !dot7_q[0][DDW-1] &&
                 !dot7_q[1][DDW-1]) begin
      rg = RegAb;
      is_edg = 1'b1;
    end else if ((sbc_q[TW-1] || sbc_q == '0) && !dot7_q[4][DDW-1] &&
                 !dot7_q[5][DDW-1]) begin
      rg = RegBc;
      is_edg = 1'b1;
      nom_sel = dot7_q[4];
      den_sel = dot7_q[5];
    end else if ((sac_q[TW-1] || sac_q == '0) && !dot7_q[2][DDW-1] &&
                 !dot7_q[3][DDW-1]) begin
      rg = RegAc;
      is_edg = 1'b1;
      nom_sel = dot7_q[2];
      den_sel = dot7_q[3];
    end
    esum = AW'(nom_sel) + AW'(den_sel);
    area = AW'(sab_q) + AW'(sbc_q) + AW'(sac_q);
    if (is_edg) begin
      num1_d = TW'(nom_sel);
      den1_d = esum;
      num2_d = '0;
      den2_d = esum;
      if (esum == '0) rg = RegDegen;
    end else begin
      num1_d = sbc_q;
      den1_d = area;
      num2_d = sac_q;
      den2_d = area;
      if (rg == RegIn && area == '0) rg = RegDegen;
    end
    side8_d = side7_q;
    side8_d.region = rg;
  end

  // divider operands: magnitudes and quotient sign
  logic            neg1, neg2;
  logic [TW-1:0]   absn1, absn2;
  logic [AW-1:0]   absd1, absd2;
  logic [NW-1:0]   nin1, nin2;

  always_comb begin
    neg1  = num1_q[TW-1] ^ den1_q[AW-1];
    neg2  = num2_q[TW-1] ^ den2_q[AW-1];
    absn1 = num1_q[TW-1] ? TW'(-num1_q) : TW'(num1_q);
    absn2 = num2_q[TW-1] ? TW'(-num2_q) : TW'(num2_q);
    absd1 = den1_q[AW-1] ? AW'(-den1_q) : AW'(den1_q);
    absd2 = den2_q[AW-1] ? AW'(-den2_q) : AW'(den2_q);
    nin1  = {absn1, {F{1'b0}}};
    nin2  = {absn2, {F{1'b0}}};
  end

  logic          dv1_vld, dv2_vld;
  logic [NW-1:0] dq1, dq2;
  logic [TGW:0]  dtag1;
  logic [0:0]    dtag2;

  cptri_div #(.NW(NW), .DENW(AW), .TAGW(TGW + 1)) u_div_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (nin1),
    .den_i   (absd1),
    .tag_i   ({neg1, side8_q}),
    .valid_o (dv1_vld),
    .quo_o   (dq1),
    .tag_o   (dtag1)
  );

  cptri_div #(.NW(NW), .DENW(AW), .TAGW(1)) u_div_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (nin2),
    .den_i   (absd2),
    .tag_i   (neg2),
    .valid_o (dv2_vld),
    .quo_o   (dq2),
    .tag_o   (dtag2)
  );

  // ---------------- stage D1: signed weights and multiplicands
  side_t                sd;
  logic signed [QW-1:0] u_d, v_d;
  logic signed [DW-1:0] x1_d [3];
  logic signed [DW-1:0] x2_d [3];

  logic                 vd_q;
  side_t                sided_q;
  logic signed [QW-1:0] u_q, v_q;
  logic signed [DW-1:0] x1_q [3];
  logic signed [DW-1:0] x2_q [3];

  always_comb begin
    sd  = side_t'(dtag1[TGW-1:0]);
    u_d = dtag1[TGW] ? -$signed({1'b0, dq1}) : $signed({1'b0, dq1});
    v_d = dtag2[0]   ? -$signed({1'b0, dq2}) : $signed({1'b0, dq2});
    for (int i = 0; i < 3; i++) begin
      case (sd.region)
        RegAb: begin
          x1_d[i] = DW'($signed(sd.b[i])) - DW'($signed(sd.a[i]));
          x2_d[i] = '0;
        end
        RegBc: begin
          x1_d[i] = DW'($signed(sd.c[i])) - DW'($signed(sd.b[i]));
          x2_d[i] = '0;
        end
        RegAc: begin
          x1_d[i] = DW'($signed(sd.c[i])) - DW'($signed(sd.a[i]));
          x2_d[i] = '0;
        end
        default: begin
          // interior: C*2^F + (A-C)*u + (B-C)*v
          x1_d[i] = DW'($signed(sd.a[i])) - DW'($signed(sd.c[i]));
          x2_d[i] = DW'($signed(sd.b[i])) - DW'($signed(sd.c[i]));
        end
      endcase
    end
  end

  // ---------------- stages M1-M2: weight products
  logic                 vm1_q, vm2_q;
  side_t                sidem1_q, sidem2_q;
  logic signed [PW-1:0] fp1 [3];
  logic signed [PW-1:0] fp2 [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    cptri_mul #(.XW(DW), .YW(QW), .K(KQ)) u_mul_u (
      .clk_i (clk_i),
      .x_i   (x1_q[i]),
      .y_i   (u_q),
      .p_o   (fp1[i])
    );
    cptri_mul #(.XW(DW), .YW(QW), .K(KQ)) u_mul_v (
      .clk_i (clk_i),
      .x_i   (x2_q[i]),
      .y_i   (v_q),
      .p_o   (fp2[i])
    );
  end

  // ---------------- stage F1: weighted sum
  logic                 vf1_q;
  side_t                sidef1_q;
  logic signed [SW-1:0] sum_q [3];
  logic signed [SW-1:0] sum_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sidem2_q.region == RegIn) begin
        sum_d[i] = (SW'($signed(sidem2_q.c[i])) <<< F) + SW'(fp1[i]) + SW'(fp2[i]);
      end else begin
        sum_d[i] = SW'(fp1[i]);
      end
    end
  end

  // ---------------- stage F2: divide by 2^F toward zero
  logic                 vf2_q;
  side_t                sidef2_q;
  logic signed [RW-1:0] tr_q [3];
  logic [SW-1:0]        bias [3];
  logic [SW-1:0]        tsum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bias[i] = sum_q[i][SW-1] ? {{(SW-F){1'b0}}, {F{1'b1}}} : '0;
      tsum[i] = SW'(sum_q[i]) + bias[i];
    end
  end

  // ---------------- stage F3: start point, saturation, output select
  logic                 stb_q;
  result_t              res_q;
  result_t              res_d;
  logic signed [VW-1:0] val [3];
  coord_t               nr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (sidef2_q.region)
        RegAb, RegAc: val[i] = VW'(tr_q[i]) + VW'($signed(sidef2_q.a[i]));
        RegBc:        val[i] = VW'(tr_q[i]) + VW'($signed(sidef2_q.b[i]));
        default:      val[i] = VW'(tr_q[i]);
      endcase
      case (sidef2_q.region)
        RegB: nr[i] = sidef2_q.b[i];
        RegC: nr[i] = sidef2_q.c[i];
        RegAb, RegBc, RegAc, RegIn: begin
          if (val[i] > SatHi) begin
            nr[i] = SatHi[C-1:0];
          end else if (val[i] < SatLo) begin
            nr[i] = SatLo[C-1:0];
          end else begin
            nr[i] = val[i][C-1:0];
          end
        end
        default: nr[i] = sidef2_q.a[i];
      endcase
    end
    res_d.near_x = nr[0];
    res_d.near_y = nr[1];
    res_d.near_z = nr[2];
    res_d.region = sidef2_q.region;
  end

  // ---------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      vd_q  <= 1'b0;
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
      stb_q <= 1'b0;
    end else begin
      v1_q  <= start && !busy;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      vd_q  <= dv1_vld;
      vm1_q <= vd_q;
      vm2_q <= vm1_q;
      vf1_q <= vm2_q;
      vf2_q <= vf1_q;
      stb_q <= vf2_q;
    end
  end

  // ---------------- datapath registers
  always_ff @(posedge clk_i) begin
    in_q    <= query_i;
    side2_q <= side1;
    for (int i = 0; i < 3; i++) begin
      ab_q[i] <= DW'(vb[i]) - DW'(va[i]);
      ac_q[i] <= DW'(vc[i]) - DW'(va[i]);
      bc_q[i] <= DW'(vc[i]) - DW'(vb[i]);
      ap_q[i] <= DW'(pt[i]) - DW'(va[i]);
      bp_q[i] <= DW'(pt[i]) - DW'(vb[i]);
      cp_q[i] <= DW'(pt[i]) - DW'(vc[i]);
    end
    side3_q <= side2_q;
    for (int j = 0; j < 8; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod3_q[j][i] <= PDW'(mx[j][i]) * PDW'(my[j][i]);
      end
    end
    side4_q <= side3_q;
    for (int j = 0; j < 8; j++) begin
      // sdenom, tdenom, udenom are negated dots
      if (j == 1 || j == 3 || j == 5) begin
        dot4_q[j] <= -dsum[j];
      end else begin
        dot4_q[j] <= dsum[j];
      end
    end
    side5_q <= side4_q;
    side6_q <= side5_q;
    side7_q <= side6_q;
    for (int j = 0; j < 6; j++) begin
      dot5_q[j] <= dot4_q[j];
      dot6_q[j] <= dot5_q[j];
      dot7_q[j] <= dot6_q[j];
    end
    sab_q   <= TW'(tp[0]) + TW'(tp[1]);
    sbc_q   <= TW'(tp[2]) - TW'(tp[3]);
    sac_q   <= TW'(tp[4]) + TW'(tp[5]);
    side8_q <= side8_d;
    num1_q  <= num1_d;
    num2_q  <= num2_d;
    den1_q  <= den1_d;
    den2_q  <= den2_d;
    sided_q <= sd;
    u_q     <= u_d;
    v_q     <= v_d;
    for (int i = 0; i < 3; i++) begin
      x1_q[i] <= x1_d[i];
      x2_q[i] <= x2_d[i];
    end
    sidem1_q <= sided_q;
    sidem2_q <= sidem1_q;
    sidef1_q <= sidem2_q;
    for (int i = 0; i < 3; i++) begin
      sum_q[i] <= sum_d[i];
      tr_q[i]  <= $signed(tsum[i][SW-1:F]);
    end
    sidef2_q <= sidef1_q;
    res_q    <= res_d;
  end

  assign res_stb_o = stb_q;
  assign result_o  = res_q;

  // ---------------- checks
  `CPT_ASSERT_IMPL(a_div_aligned, 1'b1, dv1_vld == dv2_vld, "dividers out of step")
  `CPT_ASSERT_IMPL(a_edge_weight, dv1_vld && (sd.region == RegAb || sd.region == RegBc || sd.region == RegAc), dq1 <= (NW'(1) << F), "edge weight above one")
  `CPT_ASSERT_DELAY(a_latency, start && !busy, Latency, res_stb_o, "result word missing")
  `CPT_ASSERT_IMPL(a_no_phantom, res_stb_o, $past(start && !busy, Latency), "result word without query")

endmodule

/* rtl/cptri_mul.sv */
`timescale 1ns / 1ps

// signed multiplier, y cut into K chunks; partials registered, then summed
module cptri_mul #(
  parameter int XW = 17,
  parameter int YW = 17,
  parameter int K  = 1
) (
  input  logic                 clk_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [YW-1:0] y_i,
  output logic signed [XW+YW-1:0] p_o
);

  localparam int CH   = (YW + K - 1) / K;
  localparam int TOPW = YW - (K - 1) * CH;
  localparam int PPW  = XW + CH + 1;
  localparam int OW   = XW + YW;

  logic signed [PPW-1:0] pp_q [K];
  logic signed [OW-1:0]  acc;

  for (genvar k = 0; k < K; k++) begin : g_part
    if (k < K - 1) begin : g_low
      always_ff @(posedge clk_i) begin
        pp_q[k] <= PPW'(x_i) * PPW'($signed({1'b0, y_i[k*CH +: CH]}));
      end
    end else begin : g_top
      always_ff @(posedge clk_i) begin
        pp_q[k] <= PPW'(x_i) * PPW'($signed(y_i[YW-1 -: TOPW]));
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < K; k++) begin
      acc = acc + (OW'(pp_q[k]) <<< (k * CH));
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= acc;
  end

endmodule

/* rtl/cptri_div.sv */
`timescale 1ns / 1ps

// unsigned restoring divider, one quotient bit per stage
module cptri_div #(
  parameter int NW   = 32,
  parameter int DENW = 32,
  parameter int TAGW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DENW-1:0] den_i,
  input  logic [TAGW-1:0] tag_i,
  output logic            valid_o,
  output logic [NW-1:0]   quo_o,
  output logic [TAGW-1:0] tag_o
);

  logic [DENW-1:0] rem_q [NW];
  logic [NW-1:0]   nq_q  [NW];  // numerator bits shift out, quotient bits shift in
  logic [DENW-1:0] den_q [NW];
  logic [TAGW-1:0] tag_q [NW];
  logic            vld_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DENW-1:0] rem_in;
    logic [NW-1:0]   nq_in;
    logic [DENW-1:0] den_in;
    logic [TAGW-1:0] tag_in;
    logic            vld_in;
    logic [DENW:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? DENW'(trial - {1'b0, den_in}) : trial[DENW-1:0];
      nq_q[k]  <= {nq_in[NW-2:0], ge};
      den_q[k] <= den_in;
      tag_q[k] <= tag_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = nq_q[NW-1];
  assign tag_o   = tag_q[NW-1];

endmodule

/* bench/tb_closest_point_on_triangle_unit.sv */
`timescale 1ns / 1ps

module tb_closest_point_on_triangle_unit;
  import cptri_pkg::*;

  typedef logic signed [255:0] big_t;
  typedef big_t vec_t [3];

  localparam int WFrac = 16;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 120;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  query_t  query_i = '0;
  logic    res_stb_o;
  result_t result_o;

  query_t  pending_q[$];
  result_t near_expect_q[$];
  int      mismatches = 0;
  int      gap_left = 0;
  bit      burst = 1'b0;
  int      idle_cycles = 0;

  closest_point_on_triangle_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .query_i  (query_i),
    .res_stb_o(res_stb_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic big_t dot3(vec_t x, vec_t y);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic vec_t cross3(vec_t x, vec_t y);
    vec_t r;
    r[0] = x[1] * y[2] - x[2] * y[1];
    r[1] = x[2] * y[0] - x[0] * y[2];
    r[2] = x[0] * y[1] - x[1] * y[0];
    return r;
  endfunction

  function automatic vec_t vdiff(vec_t x, vec_t y);
    vec_t r;
    for (int i = 0; i < 3; i++) r[i] = x[i] - y[i];
    return r;
  endfunction

  function automatic coord_t clamp(big_t v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v[15:0]);
  endfunction

  function automatic result_t pack_near(vec_t q, region_e rg);
    result_t r;
    r.near_x = clamp(q[0]);
    r.near_y = clamp(q[1]);
    r.near_z = clamp(q[2]);
    r.region = rg;
    return r;
  endfunction

  // start + trunc(edge * trunc(nom*2^F/(nom+den)) / 2^F)
  function automatic vec_t along_edge(vec_t s, vec_t e, big_t nom, big_t den);
    vec_t r;
    big_t one, t;
    one = big_t'(1) <<< WFrac;
    t = (nom * one) / (nom + den);
    for (int i = 0; i < 3; i++) r[i] = s[i] + (e[i] * t) / one;
    return r;
  endfunction

  function automatic result_t closest_point(query_t w);
    vec_t p, a, b, c, ab, ac, bc, ap, bp, cp, pa, pb, pc, n, q;
    big_t snom, sdenom, tnom, tdenom, unom, udenom, sab, sbc, sac, area, u, v, wt, one;
    one = big_t'(1) <<< WFrac;
    p = '{big_t'(w.point_x), big_t'(w.point_y), big_t'(w.point_z)};
    a = '{big_t'(w.vert_a_x), big_t'(w.vert_a_y), big_t'(w.vert_a_z)};
    b = '{big_t'(w.vert_b_x), big_t'(w.vert_b_y), big_t'(w.vert_b_z)};
    c = '{big_t'(w.vert_c_x), big_t'(w.vert_c_y), big_t'(w.vert_c_z)};
    ab = vdiff(b, a); ac = vdiff(c, a); bc = vdiff(c, b);
    ap = vdiff(p, a); bp = vdiff(p, b); cp = vdiff(p, c);
    pa = vdiff(a, p); pb = vdiff(b, p); pc = vdiff(c, p);
    snom = dot3(ab, ap);
    sdenom = -dot3(ab, bp);
    tnom = dot3(ac, ap);
    tdenom = -dot3(ac, cp);
    unom = dot3(bc, bp);
    udenom = -dot3(bc, cp);
    if (tnom < 0 && snom < 0) return pack_near(a, RegA);
    if (unom < 0 && sdenom < 0) return pack_near(b, RegB);
    if (udenom < 0 && tdenom < 0) return pack_near(c, RegC);
    n = cross3(ab, ac);
    sab = dot3(n, cross3(pa, pb));
    if (sab <= 0 && snom >= 0 && sdenom >= 0) begin
      if (snom + sdenom == 0) return pack_near(a, RegDegen);
      return pack_near(along_edge(a, ab, snom, sdenom), RegAb);
    end
    sbc = dot3(n, cross3(pb, pc));
    if (sbc <= 0 && unom >= 0 && udenom >= 0) begin
      if (unom + udenom == 0) return pack_near(a, RegDegen);
      return pack_near(along_edge(b, bc, unom, udenom), RegBc);
    end
    sac = dot3(n, cross3(pc, pa));
    if (sac <= 0 && tnom >= 0 && tdenom >= 0) begin
      if (tnom + tdenom == 0) return pack_near(a, RegDegen);
      return pack_near(along_edge(a, ac, tnom, tdenom), RegAc);
    end
    area = sab + sbc + sac;
    if (area == 0) return pack_near(a, RegDegen);
    u = (sbc * one) / area;
    v = (sac * one) / area;
    wt = one - u - v;
    for (int i = 0; i < 3; i++) q[i] = (a[i] * u + b[i] * v + c[i] * wt) / one;
    return pack_near(q, RegIn);
  endfunction

  task automatic add_query(int px, int py, int pz, int ax, int ay, int az,
                           int bx, int by, int bz, int cx, int cy, int cz);
    query_t w;
    w = '{coord_t'(px), coord_t'(py), coord_t'(pz), coord_t'(ax), coord_t'(ay),
          coord_t'(az), coord_t'(bx), coord_t'(by), coord_t'(bz), coord_t'(cx),
          coord_t'(cy), coord_t'(cz)};
    pending_q.push_back(w);
  endtask

  function automatic int any_coord();
    return int'(coord_t'($urandom));
  endfunction

  function automatic int near_coord(int base);
    int v;
    v = base + int'($urandom_range(0, 4000)) - 2000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // driver: one word per accepted start, random gap before the next
  always @(posedge clk_i or negedge rst_ni) begin
    bit fire, nxt;
    int w;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      nxt = start && !fire;
      w = gap_left;
      if (fire) begin
        near_expect_q.push_back(closest_point(query_i));
        if ($urandom_range(0, 29) == 0) burst = !burst;
        w = burst ? 0 : $urandom_range(0, 16);
      end
      if (!nxt) begin
        if (w > 0) w--;
        else if (pending_q.size() > 0) begin
          query_i <= pending_q.pop_front();
          nxt = 1'b1;
        end
      end
      gap_left = w;
      start <= nxt;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_stb_o) begin
      if (near_expect_q.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = near_expect_q.pop_front();
        if (result_o.near_x !== want.near_x)
          report_mismatch("near_x", result_o.near_x, want.near_x);
        if (result_o.near_y !== want.near_y)
          report_mismatch("near_y", result_o.near_y, want.near_y);
        if (result_o.near_z !== want.near_z)
          report_mismatch("near_z", result_o.near_z, want.near_z);
        if (result_o.region !== want.region)
          report_mismatch("region", result_o.region, want.region);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_stb_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int cx, cy, cz, sel;
    // vertex, edge and interior regions of a right triangle with legs of 256
    add_query(-256, -256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_query(512, -256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_query(-256, 512, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_query(128, -256, 100, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_query(256, 256, -50, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_query(-256, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_query(64, 64, 300, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_query(64, 64, -300, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    // degenerate: all vertices equal, and collinear vertices
    add_query(100, 200, 300, 5, 5, 5, 5, 5, 5, 5, 5, 5);
    add_query(-32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_query(256, 256, 0, 0, 0, 0, 256, 0, 0, 512, 0, 0);
    add_query(256, 0, 0, 0, 0, 0, 256, 0, 0, 512, 0, 0);
    add_query(300, 0, 0, 256, 0, 0, 256, 0, 0, 0, 0, 0);
    // field extremes, saturation of edge and interior points
    add_query(-32768, -32768, -32768, 32767, 32767, 32767,
              -32768, 32767, -32768, 32767, -32768, -32768);
    add_query(32767, 32767, 32767, -32768, -32768, -32768,
              32767, -32768, 32767, -32768, 32767, 32767);
    add_query(0, 0, 32767, -32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0);
    add_query(0, 0, -32768, 32767, 32767, 32767, -32768, 32767, -32768, 32767,
              -32768, -32768);
    add_query(-32768, 0, 0, 32767, -32768, 0, 32767, 32767, 0, -32768, 32767, 0);
    add_query(1, -1, 1, -1, 1, -1, 1, 1, -1, -1, -1, 1);
    for (int k = 0; k < 450; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        add_query(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                  any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                  any_coord(), any_coord());
      end else begin
        cx = any_coord(); cy = any_coord(); cz = any_coord();
        if (sel < 36) begin
          // two vertices coincide
          add_query(near_coord(cx), near_coord(cy), near_coord(cz), cx, cy, cz,
                    cx, cy, cz, near_coord(cx), near_coord(cy), near_coord(cz));
        end else if (sel < 40) begin
          // collinear triangle
          add_query(near_coord(cx), near_coord(cy), near_coord(cz), cx, cy, cz,
                    cx + 100, cy, cz, cx + 300, cy, cz);
        end else begin
          add_query(near_coord(cx), near_coord(cy), near_coord(cz),
                    near_coord(cx), near_coord(cy), near_coord(cz),
                    near_coord(cx), near_coord(cy), near_coord(cz),
                    near_coord(cx), near_coord(cy), near_coord(cz));
        end
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // poll per clock: queue sizes alone do not wake a wait
    while (pending_q.size() != 0 || start || near_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
